// ===== design/lexc_pkg.sv =====
package lexc_pkg;

	localparam int KW_COUNT    = 18;
	localparam int KW_MAX_TEXT = 8;
	localparam int OP_COUNT    = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [5:0] KIND_UNDEFINED  = 6'd0;
	localparam logic [5:0] KIND_IDENTIFIER = 6'd1;
	localparam logic [5:0] KIND_NUMBER     = 6'd2;
	localparam logic [5:0] KIND_LABEL      = 6'd3;
	localparam logic [5:0] KIND_OP_BASE    = 6'd4;
	localparam logic [5:0] KIND_KW_BASE    = 6'd20;

	localparam logic [7:0] CHAR_COLON = ":";

	localparam logic [7:0] OP_CHARS [0:OP_COUNT-1] = '{
		"=", "+", "-", "*", "/", "%", "(", ")",
		"[", "]", ",", "|", "^", "&", "<", ">"
	};

	localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:KW_MAX_TEXT-1] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"n", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"g", "o", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"e", "n", "d", "i", "f", 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"l", "o", "c", "a", "l", 8'h00, 8'h00, 8'h00},
		'{"s", "p", "a", "c", "e", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"g", "l", "o", "b", "a", "l", 8'h00, 8'h00},
		'{"p", "r", "i", "n", "t", "l", "n", 8'h00},
		'{"n", "e", "w", "l", "i", "n", "e", 8'h00},
		'{"f", "u", "n", "c", "t", "i", "o", "n"},
		'{"e", "n", "d", "w", "h", "i", "l", "e"}
	};

	localparam logic [3:0] KW_LEN [0:KW_COUNT-1] = '{
		4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5,
		4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8
	};

	// Classification of one finished lexeme, passed from front to back.
	typedef struct packed {
		logic       op_hit;
		logic [3:0] op_idx;
		logic       letters;
		logic       digits;
		logic       colon;
		logic       kw_hit;
		logic [4:0] kw_idx;
	} lexc_rec_t;

endpackage

// ===== design/lexeme_token_classifier_top.sv =====
// Lexeme token classifier: takes one byte of a lexeme per transfer on the slave
// side, with tlast on the final byte, and gives one token kind per lexeme on the
// master side. A byte can be taken in every cycle; the front end updates the
// running letter, digit and keyword-prefix flags in that cycle, and a finished
// lexeme's record is written into a two-entry queue and then taken into the back
// end's output register, which shows the token kind. The slave side only stalls
// when the queue is full, i.e. when results back up behind a stalled master side.
// Non-final bytes give no result.
module lexeme_token_classifier_top #(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [5:0] token_kind, [7:6] zero
);

	lexc_pkg::lexc_rec_t front_rec;
	lexc_pkg::lexc_rec_t head_rec;
	logic                push;
	logic                full;
	logic                pop;
	logic                not_empty;
	logic                in_fire;
	logic [5:0]          token_kind;

	assign s_tready = !full;
	assign in_fire  = s_tvalid && !full;

	lexc_front #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.char_in   (s_tdata),
		.last_char (s_tlast),
		.push      (push),
		.rec       (front_rec)
	);

	lexc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (front_rec),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head_rec)
	);

	lexc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (not_empty),
		.rec        (head_rec),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.token_kind (token_kind)
	);

	assign m_tdata = {2'b00, token_kind};

endmodule

// ===== design/lexc_front.sv =====
module lexc_front #(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           char_in,
	input  logic                 last_char,
	output logic                 push,
	output lexc_pkg::lexc_rec_t  rec
);

	localparam int CW = $clog2(MAX_KEYWORD_LEN + 2);

	logic [CW-1:0]                   length_q;
	logic                            all_letters_q;
	logic                            all_digits_q;
	logic [lexc_pkg::KW_COUNT-1:0]   alive_q;

	logic [CW-1:0]                   len_next;
	logic                            letters_next;
	logic                            digits_next;
	logic [lexc_pkg::KW_COUNT-1:0]   alive_next;
	logic                            is_letter;
	logic                            is_digit;
	logic                            pos_ok;

	assign is_letter = ((char_in >= "A") && (char_in <= "Z")) ||
	                   ((char_in >= "a") && (char_in <= "z"));
	assign is_digit  = (char_in >= "0") && (char_in <= "9");
	assign pos_ok    = length_q < CW'(lexc_pkg::KW_MAX_TEXT);

	assign len_next     = (length_q < CW'(MAX_KEYWORD_LEN + 1)) ? length_q + CW'(1) : length_q;
	assign letters_next = all_letters_q & is_letter;
	assign digits_next  = all_digits_q & is_digit;

	always_comb begin
		for (int k = 0; k < lexc_pkg::KW_COUNT; k++) begin
			alive_next[k] = alive_q[k] && pos_ok &&
			                (length_q < CW'(lexc_pkg::KW_LEN[k])) &&
			                (lexc_pkg::KW_TEXT[k][length_q[2:0]] == char_in);
		end
	end

	// Result record for the final byte of a lexeme.
	always_comb begin
		rec         = '0;
		rec.letters = letters_next;
		rec.digits  = digits_next;
		rec.colon   = (char_in == lexc_pkg::CHAR_COLON);
		// A lexeme of length one is an operator when its byte is in the list.
		if (length_q == '0) begin
			for (int k = lexc_pkg::OP_COUNT - 1; k >= 0; k--) begin
				if (lexc_pkg::OP_CHARS[k] == char_in) begin
					rec.op_hit = 1'b1;
					rec.op_idx = 4'(k);
				end
			end
		end
		// The lowest-numbered live keyword of exactly this length wins.
		for (int k = lexc_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (alive_next[k] && (len_next == CW'(lexc_pkg::KW_LEN[k]))) begin
				rec.kw_hit = 1'b1;
				rec.kw_idx = 5'(k);
			end
		end
	end

	assign push = in_fire & last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q      <= '0;
			all_letters_q <= 1'b1;
			all_digits_q  <= 1'b1;
			alive_q       <= '1;
		end else if (in_fire) begin
			if (last_char) begin
				length_q      <= '0;
				all_letters_q <= 1'b1;
				all_digits_q  <= 1'b1;
				alive_q       <= '1;
			end else begin
				length_q      <= len_next;
				all_letters_q <= letters_next;
				all_digits_q  <= digits_next;
				alive_q       <= alive_next;
			end
		end
	end

endmodule

// ===== design/lexc_queue.sv =====
module lexc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lexc_pkg::lexc_rec_t  push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output lexc_pkg::lexc_rec_t  head
);

	localparam int DEPTH = lexc_pkg::QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	lexc_pkg::lexc_rec_t entry_q [0:DEPTH-1];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [NW-1:0]       count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ===== design/lexc_back.sv =====
module lexc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rec_valid,
	input  lexc_pkg::lexc_rec_t  rec,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [5:0]           token_kind
);

	logic       valid_q;
	logic [5:0] kind_q;
	logic [5:0] kind_next;

	always_comb begin
		if (rec.op_hit) begin
			kind_next = lexc_pkg::KIND_OP_BASE + 6'(rec.op_idx);
		end else if (rec.letters || rec.colon) begin
			if (rec.kw_hit) begin
				kind_next = lexc_pkg::KIND_KW_BASE + 6'(rec.kw_idx);
			end else if (rec.colon) begin
				kind_next = lexc_pkg::KIND_LABEL;
			end else begin
				kind_next = lexc_pkg::KIND_IDENTIFIER;
			end
		end else if (rec.digits) begin
			kind_next = lexc_pkg::KIND_NUMBER;
		end else begin
			kind_next = lexc_pkg::KIND_UNDEFINED;
		end
	end

	assign pop        = rec_valid && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign token_kind = kind_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== bench/tb_lexeme_token_classifier_top.sv =====
module tb_lexeme_token_classifier_top;

	localparam int MAX_KW_LEN   = 8;
	localparam int KIND_TOTAL   = 38;
	localparam int TARGET_BYTES = 650;
	localparam int HOLD_CYCLES  = 250;
	localparam int CYCLE_LIMIT  = 300000;

	// Keeps its own copy of the lexeme state, predicts the token kind of each
	// finished lexeme and compares the results against those predictions.
	class token_scoreboard;
		string kw_words [lexc_pkg::KW_COUNT] = '{
			"if", "or", "not", "and", "then", "else", "goto", "print", "endif",
			"while", "local", "space", "return", "global", "println", "newline",
			"function", "endwhile"
		};
		string op_text = "=+-*/%()[],|^&<>";

		logic [3:0]                    len_seen;
		bit                            only_letters;
		bit                            only_digits;
		logic [7:0]                    lead_byte;
		logic [lexc_pkg::KW_COUNT-1:0] kw_alive;
		logic [5:0]                    kind_queue [$];
		bit                            kind_seen [KIND_TOTAL];
		int                            errors;
		int                            lexemes;

		function void restart();
			len_seen     = '0;
			only_letters = 1'b1;
			only_digits  = 1'b1;
			lead_byte    = '0;
			kw_alive     = '1;
		endfunction

		function void note_byte(logic [7:0] c, bit last);
			int         pos;
			bit         letter;
			bit         digit;
			logic [5:0] kind;
			pos    = len_seen;
			letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
			digit  = (c >= "0" && c <= "9");
			if (pos == 0)
				lead_byte = c;
			if (!letter)
				only_letters = 1'b0;
			if (!digit)
				only_digits = 1'b0;
			for (int k = 0; k < lexc_pkg::KW_COUNT; k++) begin
				if (!(pos < kw_words[k].len() && pos < 8 && kw_words[k][pos] == c))
					kw_alive[k] = 1'b0;
			end
			if (len_seen < MAX_KW_LEN + 1)
				len_seen++;
			if (!last)
				return;
			kind = lexc_pkg::KIND_UNDEFINED;
			if (len_seen == 1) begin
				for (int k = 0; k < 16; k++) begin
					if (kind == lexc_pkg::KIND_UNDEFINED && op_text[k] == lead_byte)
						kind = lexc_pkg::KIND_OP_BASE + 6'(k);
				end
			end
			if (kind == lexc_pkg::KIND_UNDEFINED) begin
				if (only_letters || c == ":") begin
					kind = (c == ":") ? lexc_pkg::KIND_LABEL : lexc_pkg::KIND_IDENTIFIER;
					for (int k = lexc_pkg::KW_COUNT - 1; k >= 0; k--) begin
						if (kw_alive[k] && kw_words[k].len() <= MAX_KW_LEN &&
								len_seen == kw_words[k].len())
							kind = lexc_pkg::KIND_KW_BASE + 6'(k);
					end
				end else if (only_digits) begin
					kind = lexc_pkg::KIND_NUMBER;
				end
			end
			kind_queue.push_back(kind);
			kind_seen[kind] = 1'b1;
			lexemes++;
			restart();
		endfunction

		function void check_token(logic [7:0] data);
			logic [5:0] want;
			if (kind_queue.size() == 0) begin
				$error("token_kind: no result expected, got %0d", data[5:0]);
				errors++;
				return;
			end
			want = kind_queue.pop_front();
			if (data[5:0] !== want) begin
				$error("token_kind: expected %0d, got %0d", want, data[5:0]);
				errors++;
			end
			if (data[7:6] !== 2'b00) begin
				$error("pad: expected 0, got %0d", data[7:6]);
				errors++;
			end
		endfunction

		function int pending();
			return kind_queue.size();
		endfunction

		function int kinds_covered();
			int n;
			n = 0;
			foreach (kind_seen[i])
				if (kind_seen[i])
					n++;
			return n;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	token_scoreboard sb = new();

	logic [7:0] lex_bytes [$];
	bit         tx_quiet;
	bit         rx_quiet;
	bit         hold_request;
	int         bytes_sent;
	int         cycles;

	lexeme_token_classifier_top #(
		.MAX_KEYWORD_LEN(MAX_KW_LEN)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("lexeme_token_classifier_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_byte(s_tdata, s_tlast);
			bytes_sent <= bytes_sent + 1;
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check_token(m_tdata);
	end

	// Receiver: random stalls per result, plus one long hold-off on request.
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = rx_quiet ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
			: 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	task automatic send_byte(input logic [7:0] c, input bit last);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_lexeme();
		for (int i = 0; i < lex_bytes.size(); i++)
			send_byte(lex_bytes[i], i == lex_bytes.size() - 1);
	endtask

	task automatic send_word(input string s);
		lex_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			lex_bytes.push_back(s[i]);
		send_lexeme();
	endtask

	// The sender goes idle first, and the monitor has noted the last transfer
	// before the count of outstanding results is looked at.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Most lexemes are well formed (operators, keywords, labels, names, numbers);
	// the rest are near-miss keywords and arbitrary bytes.
	task automatic build_lexeme();
		int    pick;
		int    n;
		int    pos;
		string w;
		lex_bytes.delete();
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				lex_bytes.push_back(sb.op_text[$urandom_range(0, 15)]);
			end
			1, 2, 3: begin
				w = sb.kw_words[$urandom_range(0, lexc_pkg::KW_COUNT - 1)];
				for (int i = 0; i < w.len(); i++)
					lex_bytes.push_back(w[i]);
				if (pick == 2) begin
					lex_bytes.push_back(lexc_pkg::CHAR_COLON);
				end else if (pick == 3) begin
					case ($urandom_range(0, 3))
						0: void'(lex_bytes.pop_back());
						1: lex_bytes.push_back(rand_letter());
						2: begin
							pos = $urandom_range(0, lex_bytes.size() - 1);
							lex_bytes[pos] = rand_letter();
						end
						default: lex_bytes[0] = lex_bytes[0] - 8'h20;
					endcase
				end
			end
			4, 5: begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
					: $urandom_range(1, 8);
				repeat (n) lex_bytes.push_back(rand_letter());
				if (pick == 5)
					lex_bytes.push_back(lexc_pkg::CHAR_COLON);
			end
			6: begin
				n = $urandom_range(1, 12);
				repeat (n) lex_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
			end
			7: begin
				n = $urandom_range(1, 10);
				repeat (n) lex_bytes.push_back(8'($urandom_range(1, 255)));
			end
			8: begin
				n = $urandom_range(0, 6);
				repeat (n) lex_bytes.push_back(rand_letter());
				lex_bytes.push_back(8'($urandom_range(1, 255)));
			end
			default: begin
				lex_bytes.push_back(8'($urandom_range(1, 255)));
			end
		endcase
	endtask

	initial begin
		int round;
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tlast      <= 1'b0;
		m_tready     <= 1'b0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		hold_request = 1'b0;
		bytes_sent   = 0;
		cycles       = 0;
		sb.restart();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operator extremes, lone colon, keyword lengths, number,
		// label, top byte value, mixed text and a saturated length.
		send_word("=");
		send_word(">");
		send_word(":");
		send_word("if");
		send_word("endwhile");
		send_word("7");
		send_word("x:");
		lex_bytes = '{8'hFF};
		send_lexeme();
		send_word("a1");
		send_word("functions");
		wait_drained();

		round = 0;
		while (bytes_sent < TARGET_BYTES) begin
			if (round % 40 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			if (round == 60) begin
				// Back the results up so that the input side has to stall.
				hold_request = 1'b1;
				tx_quiet     = 1'b1;
			end
			if (round == 100 || round == 180)
				wait_drained();
			build_lexeme();
			send_lexeme();
			round++;
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Run covered %0d lexemes over %0d byte transfers, %0d of %0d token kinds,",
			sb.lexemes, bytes_sent, sb.kinds_covered(), KIND_TOTAL);
		$display("with random gaps on both sides and one long output hold-off.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("lexeme_token_classifier_top: match");
		end else begin
			$display("lexeme_token_classifier_top: mismatch");
		end
		$finish;
	end

endmodule

// ===== lexeme_token_classifier_top.f =====
design/lexc_pkg.sv
design/lexc_front.sv
design/lexc_queue.sv
design/lexc_back.sv
design/lexeme_token_classifier_top.sv
bench/tb_lexeme_token_classifier_top.sv
